### rtl/sma_pkg.sv
// shared types and constants of the symbolic mode applier
package sma_pkg;

  localparam int ModeW  = 12;
  localparam int PermW  = 9;
  localparam int CharW  = 8;
  localparam int StartW = 16;
  localparam int ErrW   = 2;

  localparam logic [ModeW-1:0] MODE_MASK   = 12'o7777;
  localparam logic [PermW-1:0] ALL_CLASSES = 9'h1FF;
  localparam logic [PermW-1:0] USER_BITS   = 9'h1C0;
  localparam logic [PermW-1:0] GROUP_BITS  = 9'h038;
  localparam logic [PermW-1:0] OTHER_BITS  = 9'h007;
  localparam logic [PermW-1:0] READ_BITS   = 9'h124;
  localparam logic [PermW-1:0] WRITE_BITS  = 9'h092;
  localparam logic [PermW-1:0] EXEC_BITS   = 9'h049;

  localparam logic [CharW-1:0] CH_U     = 8'h75;
  localparam logic [CharW-1:0] CH_G     = 8'h67;
  localparam logic [CharW-1:0] CH_O     = 8'h6F;
  localparam logic [CharW-1:0] CH_A     = 8'h61;
  localparam logic [CharW-1:0] CH_R     = 8'h72;
  localparam logic [CharW-1:0] CH_W     = 8'h77;
  localparam logic [CharW-1:0] CH_X     = 8'h78;
  localparam logic [CharW-1:0] CH_COMMA = 8'h2C;
  localparam logic [CharW-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CharW-1:0] CH_MINUS = 8'h2D;
  localparam logic [CharW-1:0] CH_EQUAL = 8'h3D;

  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_ADD  = 2'd1,
    OP_SUB  = 2'd2,
    OP_SET  = 2'd3
  } op_t;

  typedef enum logic [ErrW-1:0] {
    ERR_NONE  = 2'd0,
    ERR_CLASS = 2'd1,
    ERR_NO_OP = 2'd2,
    ERR_PERM  = 2'd3
  } err_t;

  typedef struct packed {
    logic             in_perm_phase;
    logic             clause_started;
    logic [PermW-1:0] class_mask;
    op_t              pending_operator;
    logic [PermW-1:0] perm_bits;
    logic [ModeW-1:0] working_mode;
    err_t             first_error;
  } state_t;

  localparam state_t STATE_RESET = '{
    in_perm_phase:    1'b0,
    clause_started:   1'b0,
    class_mask:       '0,
    pending_operator: OP_NONE,
    perm_bits:        '0,
    working_mode:     '0,
    first_error:      ERR_NONE
  };

endpackage

### rtl/sma_step.sv
// next-state and result logic for one mode string character
module sma_step (
  input  sma_pkg::state_t                  state_q,
  input  logic [sma_pkg::CharW-1:0]        ch,
  input  logic                             has_char,
  input  logic                             first,
  input  logic                             last,
  input  logic [sma_pkg::ModeW-1:0]        start_mode,
  output sma_pkg::state_t                  state_nxt,
  output logic [sma_pkg::ModeW-1:0]        res_mode,
  output sma_pkg::err_t                    res_err
);
  import sma_pkg::*;

  function automatic op_t op_code(input logic [CharW-1:0] c);
    op_t op;
    op = OP_NONE;
    if (c == CH_PLUS) op = OP_ADD;
    else if (c == CH_MINUS) op = OP_SUB;
    else if (c == CH_EQUAL) op = OP_SET;
    return op;
  endfunction

  function automatic logic [ModeW-1:0] apply_clause(input state_t s);
    logic [ModeW-1:0] wm;
    logic [ModeW-1:0] pb;
    logic [ModeW-1:0] cm;
    pb = {{(ModeW-PermW){1'b0}}, s.perm_bits};
    cm = {{(ModeW-PermW){1'b0}}, s.class_mask};
    wm = s.working_mode;
    unique case (s.pending_operator)
      OP_ADD:  wm = wm | pb;
      OP_SUB:  wm = wm & ~pb;
      OP_SET:  wm = (wm & ~cm) | pb;
      default: wm = s.working_mode;
    endcase
    return wm & MODE_MASK;
  endfunction

  function automatic state_t clear_clause(input state_t s);
    state_t t;
    t = s;
    t.in_perm_phase    = 1'b0;
    t.clause_started   = 1'b0;
    t.class_mask       = '0;
    t.pending_operator = OP_NONE;
    t.perm_bits        = '0;
    return t;
  endfunction

  state_t s;
  op_t    op;

  always_comb begin
    s  = state_q;
    op = op_code(ch);
    res_mode = '0;
    res_err  = ERR_NONE;

    if (first) begin
      s = clear_clause(s);
      s.first_error  = ERR_NONE;
      s.working_mode = start_mode & MODE_MASK;
    end

    if (has_char && s.first_error == ERR_NONE) begin
      if (!s.in_perm_phase) begin
        priority if (ch == CH_U) begin
          s.class_mask     = s.class_mask | USER_BITS;
          s.clause_started = 1'b1;
        end else if (ch == CH_G) begin
          s.class_mask     = s.class_mask | GROUP_BITS;
          s.clause_started = 1'b1;
        end else if (ch == CH_O) begin
          s.class_mask     = s.class_mask | OTHER_BITS;
          s.clause_started = 1'b1;
        end else if (ch == CH_A) begin
          s.class_mask     = ALL_CLASSES;
          s.clause_started = 1'b1;
        end else if (op != OP_NONE) begin
          if (s.class_mask == '0) s.class_mask = ALL_CLASSES;
          s.pending_operator = op;
          s.perm_bits        = '0;
          s.in_perm_phase    = 1'b1;
        end else begin
          s.first_error = ERR_CLASS;
        end
      end else begin
        priority if (ch == CH_R) begin
          s.perm_bits = s.perm_bits | (READ_BITS & s.class_mask);
        end else if (ch == CH_W) begin
          s.perm_bits = s.perm_bits | (WRITE_BITS & s.class_mask);
        end else if (ch == CH_X) begin
          s.perm_bits = s.perm_bits | (EXEC_BITS & s.class_mask);
        end else if (ch == CH_COMMA) begin
          s.working_mode = apply_clause(s);
          s = clear_clause(s);
        end else if (op != OP_NONE) begin
          s.working_mode     = apply_clause(s);
          s.class_mask       = ALL_CLASSES;
          s.pending_operator = op;
          s.perm_bits        = '0;
          s.clause_started   = 1'b1;
        end else begin
          s.first_error = ERR_PERM;
        end
      end
    end

    if (last) begin
      if (s.first_error == ERR_NONE) begin
        if (s.in_perm_phase) s.working_mode = apply_clause(s);
        else if (s.clause_started) s.first_error = ERR_NO_OP;
      end
      res_mode = (s.first_error == ERR_NONE) ? s.working_mode : '0;
      res_err  = s.first_error;
      s = clear_clause(s);
      s.first_error = ERR_NONE;
    end

    state_nxt = s;
  end

endmodule

### rtl/symbolic_mode_applier_top.sv
// top level of the symbolic mode applier: input stage, clause state, result register
//
// channel   direction  handshake               payload
// in_       input      in_valid / in_ready     ch, has_char, first, last, start_mode
// out_      output     out_valid / out_ready   new_mode, error_code
//
// one character per cycle while not stalled: an item is held in the input stage, then the
// clause state and, on a last item, the result register are updated
// a last item passes the input stage and then the result register, which drives out_valid
// the input stage stalls only while it holds a last item and the result is not taken
// synchronous active-low reset clears the stage valids and the clause state
module symbolic_mode_applier_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [sma_pkg::CharW-1:0]     in_ch,
  input  logic                          in_has_char,
  input  logic                          in_first,
  input  logic                          in_last,
  input  logic [sma_pkg::StartW-1:0]    in_start_mode,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sma_pkg::ModeW-1:0]     out_new_mode,
  output logic [sma_pkg::ErrW-1:0]      out_error_code
);
  import sma_pkg::*;

  logic             s1_valid_r;
  logic [CharW-1:0] s1_ch_r;
  logic             s1_has_char_r;
  logic             s1_first_r;
  logic             s1_last_r;
  logic [ModeW-1:0] s1_start_r;

  state_t           state_r;
  state_t           state_nxt;
  logic [ModeW-1:0] res_mode;
  err_t             res_err;

  logic             out_valid_r;
  logic             out_valid_nxt;
  logic [ModeW-1:0] out_mode_r;
  err_t             out_err_r;

  logic             advance;
  logic             accept;

  assign advance  = s1_valid_r && (!s1_last_r || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;
  assign accept   = in_valid && in_ready;

  sma_step u_step (
    .state_q    (state_r),
    .ch         (s1_ch_r),
    .has_char   (s1_has_char_r),
    .first      (s1_first_r),
    .last       (s1_last_r),
    .start_mode (s1_start_r),
    .state_nxt  (state_nxt),
    .res_mode   (res_mode),
    .res_err    (res_err)
  );

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ch_r       <= in_ch;
      s1_has_char_r <= in_has_char;
      s1_first_r    <= in_first;
      s1_last_r     <= in_last;
      s1_start_r    <= in_start_mode[ModeW-1:0];
    end
  end

  // clause state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_RESET;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (advance && s1_last_r) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_last_r) begin
      out_mode_r <= res_mode;
      out_err_r  <= res_err;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_new_mode   = out_mode_r;
  assign out_error_code = ErrW'(out_err_r);

  a_err_zero_mode : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_err_r == ERR_NONE || out_mode_r == '0))
    else $error("error result carries a nonzero mode");

  a_clear_after_last : assert property (@(posedge clk) disable iff (!rst_n)
    (advance && s1_last_r) |=>
      (state_r.first_error == ERR_NONE && !state_r.in_perm_phase
       && state_r.pending_operator == OP_NONE))
    else $error("clause state not cleared after last item");

  a_perm_has_op : assert property (@(posedge clk) disable iff (!rst_n)
    state_r.in_perm_phase |-> state_r.pending_operator != OP_NONE)
    else $error("permission phase without operator");

  a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && s1_last_r && out_valid_r && !out_ready))
    else $error("input stalled without a blocked result");

endmodule
